[hw/rtl/dtc_pkg.sv]
// Shared types and constants of the dual timer/counter register block.
package dtc_pkg;

  localparam int unsigned CountWidth    = 28;
  localparam int unsigned PrescaleWidth = 16;
  localparam int unsigned DividerLsb    = 16;

  localparam logic [1:0] ActRead  = 2'd0;
  localparam logic [1:0] ActWrite = 2'd1;
  localparam logic [1:0] ActTick  = 2'd2;

  localparam logic [2:0] RegData0   = 3'd0;
  localparam logic [2:0] RegData1   = 3'd1;
  localparam logic [2:0] RegCount0  = 3'd2;
  localparam logic [2:0] RegCount1  = 3'd3;
  localparam logic [2:0] RegCtrl    = 3'd4;
  localparam logic [2:0] RegIrq     = 3'd5;
  localparam logic [2:0] RegDivider = 3'd6;

  localparam int unsigned CtrlEn0Bit   = 31;
  localparam int unsigned CtrlMode0Bit = 30;
  localparam int unsigned CtrlEn1Bit   = 29;
  localparam int unsigned CtrlMode1Bit = 28;

  localparam int unsigned IrqEn0Bit   = 31;
  localparam int unsigned IrqEn1Bit   = 30;
  localparam int unsigned IrqPend0Bit = 29;
  localparam int unsigned IrqPend1Bit = 28;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
  } dtc_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line;
  } dtc_rsp_t;

endpackage

[hw/rtl/dual_timer_counter_registers_unit.sv]
// Dual timer/counter with shared prescaler behind seven word registers.
//
//  Channel   Direction  Handshake               Payload
//  request   in         in_valid_i / in_stall_o  in_req_i  (dtc_req_t)
//  response  out        out_valid_o / out_stall_i out_rsp_o (dtc_rsp_t)
//
// Each request passes from the input register through the register and timer
// update logic into the response register, which drives out_rsp_o.
// One request is accepted every cycle while the response side does not stall.
// A stall on the response side holds both stages and stalls the request side.
// Reset clears all timer, control and prescaler state to zero.
module dual_timer_counter_registers_unit
  import dtc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH    = CountWidth,
  parameter int unsigned PRESCALE_WIDTH = PrescaleWidth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dtc_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dtc_rsp_t out_rsp_o
);

  localparam int unsigned CountShift = 32 - COUNT_WIDTH;

  logic                      in_valid_q;
  dtc_req_t                  req_q;
  logic                      out_valid_q;
  dtc_rsp_t                  rsp_q, rsp_d;
  logic                      advance, fire;

  logic [COUNT_WIDTH-1:0]    reload_q [2];
  logic [COUNT_WIDTH-1:0]    reload_d [2];
  logic [COUNT_WIDTH-1:0]    count_q  [2];
  logic [COUNT_WIDTH-1:0]    count_d  [2];
  logic [1:0]                enable_q, enable_d;
  logic [1:0]                mode_q, mode_d;
  logic [1:0]                irq_en_q, irq_en_d;
  logic [1:0]                pending_q, pending_d;
  logic [PRESCALE_WIDTH-1:0] factor_q, factor_d;
  logic [PRESCALE_WIDTH-1:0] pre_cnt_q, pre_cnt_d;
  logic [PRESCALE_WIDTH:0]   pre_next;
  logic [COUNT_WIDTH-1:0]    cnt_next [2];
  logic [1:0]                new_en, rising;

  assign advance     = !out_valid_q || !out_stall_i;
  assign fire        = in_valid_q && advance;
  assign in_stall_o  = in_valid_q && !advance;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  assign pre_next = {1'b0, pre_cnt_q} + {{PRESCALE_WIDTH{1'b0}}, 1'b1};
  assign cnt_next[0] = count_q[0] + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
  assign cnt_next[1] = count_q[1] + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
  assign new_en = {req_q.write_data[CtrlEn1Bit], req_q.write_data[CtrlEn0Bit]};
  assign rising = new_en & ~enable_q;

  always_comb begin
    reload_d  = reload_q;
    count_d   = count_q;
    enable_d  = enable_q;
    mode_d    = mode_q;
    irq_en_d  = irq_en_q;
    pending_d = pending_q;
    factor_d  = factor_q;
    pre_cnt_d = pre_cnt_q;
    rsp_d.read_data = '0;

    if (fire) begin
      unique case (req_q.action)
        ActRead: begin
          unique case (req_q.reg_index)
            RegData0:   rsp_d.read_data = 32'(reload_q[0]) << CountShift;
            RegData1:   rsp_d.read_data = 32'(reload_q[1]) << CountShift;
            RegCount0:  rsp_d.read_data = 32'(count_q[0]) << CountShift;
            RegCount1:  rsp_d.read_data = 32'(count_q[1]) << CountShift;
            RegCtrl: begin
              rsp_d.read_data[CtrlEn0Bit]   = enable_q[0];
              rsp_d.read_data[CtrlMode0Bit] = mode_q[0];
              rsp_d.read_data[CtrlEn1Bit]   = enable_q[1];
              rsp_d.read_data[CtrlMode1Bit] = mode_q[1];
            end
            RegIrq: begin
              rsp_d.read_data[IrqEn0Bit]   = irq_en_q[0];
              rsp_d.read_data[IrqEn1Bit]   = irq_en_q[1];
              rsp_d.read_data[IrqPend0Bit] = pending_q[0];
              rsp_d.read_data[IrqPend1Bit] = pending_q[1];
            end
            RegDivider: rsp_d.read_data = 32'(factor_q) << DividerLsb;
            default:    rsp_d.read_data = '0;
          endcase
        end
        ActWrite: begin
          unique case (req_q.reg_index)
            RegData0: reload_d[0] = COUNT_WIDTH'(req_q.write_data >> CountShift);
            RegData1: reload_d[1] = COUNT_WIDTH'(req_q.write_data >> CountShift);
            RegCtrl: begin
              if (rising[0]) count_d[0] = '0;
              if (rising[1]) count_d[1] = '0;
              enable_d = new_en;
              mode_d   = {req_q.write_data[CtrlMode1Bit], req_q.write_data[CtrlMode0Bit]};
            end
            RegIrq: begin
              irq_en_d  = {req_q.write_data[IrqEn1Bit], req_q.write_data[IrqEn0Bit]};
              pending_d = pending_q &
                          ~{req_q.write_data[IrqPend1Bit], req_q.write_data[IrqPend0Bit]};
            end
            RegDivider: factor_d = req_q.write_data[DividerLsb +: PRESCALE_WIDTH];
            default: ;
          endcase
        end
        ActTick: begin
          if (pre_next >= {1'b0, factor_q}) begin
            pre_cnt_d = '0;
            for (int t = 0; t < 2; t++) begin
              if (enable_q[t]) begin
                if (cnt_next[t] == reload_q[t]) begin
                  pending_d[t] = 1'b1;
                  if (mode_q[t]) begin
                    count_d[t] = '0;
                  end else begin
                    count_d[t]  = cnt_next[t];
                    enable_d[t] = 1'b0;
                  end
                end else begin
                  count_d[t] = cnt_next[t];
                end
              end
            end
          end else begin
            pre_cnt_d = pre_next[PRESCALE_WIDTH-1:0];
          end
        end
        default: ;
      endcase
    end

    rsp_d.irq_line = |(pending_d & irq_en_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      reload_q[0] <= '0;
      reload_q[1] <= '0;
      count_q[0]  <= '0;
      count_q[1]  <= '0;
      enable_q    <= '0;
      mode_q      <= '0;
      irq_en_q    <= '0;
      pending_q   <= '0;
      factor_q    <= '0;
      pre_cnt_q   <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      reload_q  <= reload_d;
      count_q   <= count_d;
      enable_q  <= enable_d;
      mode_q    <= mode_d;
      irq_en_q  <= irq_en_d;
      pending_q <= pending_d;
      factor_q  <= factor_d;
      pre_cnt_q <= pre_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q <= in_req_i;
    end
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the dual timer/counter register block.
`timescale 1ns / 1ps

module testbench
  import dtc_pkg::*;
();

  localparam logic [1:0] ActNone   = 2'd3;
  localparam logic [2:0] RegUnused = 3'd7;
  localparam int unsigned Shift      = 32 - CountWidth;
  localparam int unsigned CycleLimit = 200000;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  dtc_req_t in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  dtc_rsp_t out_rsp_o;

  dual_timer_counter_registers_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [CountWidth-1:0]    reload_q [2] = '{default: '0};
  logic [CountWidth-1:0]    count_q  [2] = '{default: '0};
  logic [1:0]               enable_q       = '0;
  logic [1:0]               mode_q         = '0;
  logic [1:0]               irq_en_q       = '0;
  logic [1:0]               pend_q         = '0;
  logic [PrescaleWidth-1:0] prescale_q     = '0;
  logic [PrescaleWidth-1:0] prescale_cnt_q = '0;

  dtc_rsp_t    predicted_rsps [$];
  dtc_rsp_t    exp_rsp;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned useful_reqs   = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;

  function automatic dtc_rsp_t timer_model_step(input dtc_req_t req);
    dtc_rsp_t              rsp;
    logic [1:0]            en_new;
    logic [1:0]            rising;
    logic [CountWidth-1:0] nxt;
    logic [31:0]           wd;
    wd = req.write_data;
    rsp.read_data = '0;
    case (req.action)
      ActRead: begin
        case (req.reg_index)
          RegData0:  rsp.read_data = {reload_q[0], {Shift{1'b0}}};
          RegData1:  rsp.read_data = {reload_q[1], {Shift{1'b0}}};
          RegCount0: rsp.read_data = {count_q[0], {Shift{1'b0}}};
          RegCount1: rsp.read_data = {count_q[1], {Shift{1'b0}}};
          RegCtrl: begin
            rsp.read_data[CtrlEn0Bit]   = enable_q[0];
            rsp.read_data[CtrlMode0Bit] = mode_q[0];
            rsp.read_data[CtrlEn1Bit]   = enable_q[1];
            rsp.read_data[CtrlMode1Bit] = mode_q[1];
          end
          RegIrq: begin
            rsp.read_data[IrqEn0Bit]   = irq_en_q[0];
            rsp.read_data[IrqEn1Bit]   = irq_en_q[1];
            rsp.read_data[IrqPend0Bit] = pend_q[0];
            rsp.read_data[IrqPend1Bit] = pend_q[1];
          end
          RegDivider: rsp.read_data[DividerLsb +: PrescaleWidth] = prescale_q;
          default: rsp.read_data = '0;
        endcase
      end
      ActWrite: begin
        case (req.reg_index)
          RegData0: reload_q[0] = wd[31:Shift];
          RegData1: reload_q[1] = wd[31:Shift];
          RegCtrl: begin
            en_new = {wd[CtrlEn1Bit], wd[CtrlEn0Bit]};
            rising = en_new & ~enable_q;
            if (rising[0]) count_q[0] = '0;
            if (rising[1]) count_q[1] = '0;
            enable_q = en_new;
            mode_q   = {wd[CtrlMode1Bit], wd[CtrlMode0Bit]};
          end
          RegIrq: begin
            irq_en_q = {wd[IrqEn1Bit], wd[IrqEn0Bit]};
            pend_q   = pend_q & ~{wd[IrqPend1Bit], wd[IrqPend0Bit]};
          end
          RegDivider: prescale_q = wd[DividerLsb +: PrescaleWidth];
          default: ;
        endcase
      end
      ActTick: begin
        if (32'(prescale_cnt_q) + 32'd1 >= 32'(prescale_q)) begin
          prescale_cnt_q = '0;
          for (int t = 0; t < 2; t++) begin
            if (enable_q[t]) begin
              nxt = count_q[t] + 1'b1;
              if (nxt == reload_q[t]) begin
                pend_q[t] = 1'b1;
                if (mode_q[t]) begin
                  count_q[t] = '0;
                end else begin
                  count_q[t]  = nxt;
                  enable_q[t] = 1'b0;
                end
              end else begin
                count_q[t] = nxt;
              end
            end
          end
        end else begin
          prescale_cnt_q = prescale_cnt_q + 1'b1;
        end
      end
      default: ;
    endcase
    rsp.irq_line = |(pend_q & irq_en_q);
    return rsp;
  endfunction

  function automatic dtc_req_t req_of(input logic [1:0] act, input logic [2:0] idx,
                                      input logic [31:0] data);
    dtc_req_t req;
    req.action     = act;
    req.reg_index  = idx;
    req.write_data = data;
    return req;
  endfunction

  task automatic send_req(input dtc_req_t req);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    predicted_rsps.push_back(timer_model_step(req));
    if (!(req.action == ActNone || (req.action == ActWrite &&
          (req.reg_index == RegCount0 || req.reg_index == RegCount1 ||
           req.reg_index == RegUnused))))
      useful_reqs++;
  endtask

  task automatic drain_responses();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (predicted_rsps.size() != 0);
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] expected,
                               input logic [31:0] actual);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, expected, actual);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_rsps.size() == 0) begin
        note_mismatch("unexpected response", 32'h0, out_rsp_o.read_data);
      end else begin
        exp_rsp = predicted_rsps.pop_front();
        if (out_rsp_o.read_data !== exp_rsp.read_data)
          note_mismatch("read_data", exp_rsp.read_data, out_rsp_o.read_data);
        if (out_rsp_o.irq_line !== exp_rsp.irq_line)
          note_mismatch("irq_line", 32'(exp_rsp.irq_line), 32'(out_rsp_o.irq_line));
      end
    end
    out_stall_i <= ($urandom_range(99, 0) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_reset_values();
    for (int i = 0; i < 8; i++) send_req(req_of(ActRead, 3'(i), $urandom));
  endtask

  task automatic test_register_access();
    send_req(req_of(ActWrite, RegData0, 32'hFFFF_FFFF));
    send_req(req_of(ActWrite, RegData1, 32'h0000_000F));
    send_req(req_of(ActWrite, RegCount0, 32'hFFFF_FFFF));
    send_req(req_of(ActWrite, RegUnused, 32'hFFFF_FFFF));
    send_req(req_of(ActNone, RegCtrl, 32'hFFFF_FFFF));
    send_req(req_of(ActWrite, RegDivider, 32'hFFFF_FFFF));
    send_req(req_of(ActWrite, RegCtrl, 32'hFFFF_FFFF));
    send_req(req_of(ActWrite, RegIrq, 32'hFFFF_FFFF));
    send_req(req_of(ActRead, RegData0, 32'h0));
    send_req(req_of(ActRead, RegData1, 32'h0));
    send_req(req_of(ActRead, RegCount0, 32'h0));
    send_req(req_of(ActRead, RegDivider, 32'h0));
    send_req(req_of(ActRead, RegCtrl, 32'h0));
    send_req(req_of(ActRead, RegIrq, 32'h0));
    send_req(req_of(ActWrite, RegCtrl, 32'h0));
  endtask

  task automatic test_timer_expiry();
    logic [31:0] ctrl_val;
    ctrl_val = '0;
    ctrl_val[CtrlEn0Bit]   = 1'b1;
    ctrl_val[CtrlEn1Bit]   = 1'b1;
    ctrl_val[CtrlMode1Bit] = 1'b1;
    send_req(req_of(ActWrite, RegDivider, 32'd2 << DividerLsb));
    send_req(req_of(ActWrite, RegData0, 32'd3 << Shift));
    send_req(req_of(ActWrite, RegData1, 32'd2 << Shift));
    send_req(req_of(ActWrite, RegIrq, 32'd1 << IrqEn0Bit));
    send_req(req_of(ActWrite, RegCtrl, ctrl_val));
    repeat (7) send_req(req_of(ActTick, RegData0, $urandom));
    send_req(req_of(ActRead, RegCount0, 32'h0));
    send_req(req_of(ActRead, RegCtrl, 32'h0));
    send_req(req_of(ActRead, RegIrq, 32'h0));
    send_req(req_of(ActWrite, RegCtrl, ctrl_val));
    send_req(req_of(ActRead, RegCount1, 32'h0));
    send_req(req_of(ActWrite, RegDivider, 32'h0000_FFFF));
    repeat (3) send_req(req_of(ActTick, RegIrq, $urandom));
    send_req(req_of(ActRead, RegCount0, 32'h0));
    send_req(req_of(ActWrite, RegIrq, (32'd1 << IrqEn0Bit) | (32'd1 << IrqPend0Bit)));
    send_req(req_of(ActRead, RegIrq, 32'h0));
    drain_responses();
  endtask

  task automatic test_random_traffic(input int unsigned target);
    int unsigned stop_at;
    int unsigned len;
    int unsigned pick;
    logic [31:0] d;
    stop_at = useful_reqs + target;
    while (useful_reqs < stop_at) begin
      if ($urandom_range(9, 0) < 7) begin
        d = $urandom;
        if ($urandom_range(7, 0) != 0) d[31:Shift] = CountWidth'($urandom_range(24, 0));
        send_req(req_of(ActWrite, $urandom_range(1, 0) ? RegData1 : RegData0, d));
        if ($urandom_range(1, 0) != 0) begin
          d = $urandom;
          d[DividerLsb +: PrescaleWidth] = PrescaleWidth'($urandom_range(3, 0));
          send_req(req_of(ActWrite, RegDivider, d));
        end
        if ($urandom_range(1, 0) != 0) send_req(req_of(ActWrite, RegIrq, $urandom));
        send_req(req_of(ActWrite, RegCtrl, $urandom));
        len = $urandom_range(30, 6);
        for (int unsigned i = 0; i < len; i++) begin
          pick = $urandom_range(9, 0);
          if (pick < 6)
            send_req(req_of(ActTick, 3'($urandom), $urandom));
          else if (pick < 9)
            send_req(req_of(ActRead, 3'($urandom_range(7, 0)), $urandom));
          else
            send_req(req_of(ActWrite, RegIrq, $urandom));
        end
      end else begin
        repeat ($urandom_range(6, 1))
          send_req(req_of(2'($urandom), 3'($urandom), $urandom));
      end
      if ($urandom_range(19, 0) == 0) drain_responses();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 17;
    recv_idle_pct = 75;
    test_reset_values();
    test_register_access();
    test_timer_expiry();
    test_random_traffic(130);
    send_idle_pct = 75;
    recv_idle_pct = 17;
    test_random_traffic(130);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(130);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (predicted_rsps.size() != 0);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
